// ----- rtl/core/gclt_pkg.sv -----
// ----------------------------------------------------------------------------
// gclt_pkg: shared types and constants of the glyph cache tag store
// Key, entry and result layouts, field widths and beat kind codes.
// ----------------------------------------------------------------------------
package gclt_pkg;

    // Default number of cache slots
    localparam int ENTRIES_DEF = 512;

    // Field widths
    localparam int GLYPH_W   = 16;
    localparam int SIZE_W    = 8;
    localparam int STYLE_W   = 16;
    localparam int ANGLE_W   = 32;
    localparam int STAMP_W   = 32;
    localparam int SLOT_W    = 9;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    // Beat kinds carried on s_tuser
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // Lookup key, glyph in the lowest bits
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [STYLE_W-1:0] style;
        logic [SIZE_W-1:0]  size;
        logic [GLYPH_W-1:0] glyph;
    } key_t;

    // One stored slot: key plus use stamp
    typedef struct packed {
        key_t               key;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Result of one beat
    typedef struct packed {
        logic              evicted;
        logic [SLOT_W-1:0] slot;
        logic              hit;
    } result_t;

endpackage

// ----- rtl/core/glyph_cache_lru_tag_store.sv -----
// ----------------------------------------------------------------------------
// glyph_cache_lru_tag_store: tag and LRU replacement store of a glyph cache
// Fully associative lookup with allocate on miss and least-recently-used
// eviction; one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one beat per request. s_tuser selects an access
//   (lookup, allocate on miss) or a flush of all slots. The m_ channel
//   returns hit, slot and evicted for every request, in order.
//   Filled slots always form a contiguous range starting at slot 0, so a
//   fill count stands in for per-slot valid bits and no clearing pass is
//   needed after reset or flush.
//   An access scans the filled slots through the single read port of the
//   entry RAM, one slot per cycle, stopping at the first match; a flush
//   does no scan.
//   One request is worked on at a time; s_tready is high while the
//   sequencer is idle. The result sits in an output register, so the next
//   request is taken while m_tvalid waits on m_tready; a stalled receiver
//   holds the following request in its write-back or flush step.
//   Reset empties the cache and clears the use counter; the block is ready
//   in the first cycle after reset.
// ----------------------------------------------------------------------------
module glyph_cache_lru_tag_store #(
    parameter int CACHE_ENTRIES = gclt_pkg::ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // glyph_index[15:0], pixel_size[23:16], style_bits[39:24], angle_fixed[71:40]
    input  logic [gclt_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit[0], slot[9:1], evicted[10], zero fill [15:11]
    output logic [gclt_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic                                 accept;
    logic                                 out_free;
    logic                                 idle;
    logic                                 res_valid;
    gclt_pkg::result_t                    res;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [gclt_pkg::M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = idle;
    assign out_free = !m_tvalid_reg || m_tready;

    gclt_ctrl #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .start_kind (s_tuser),
        .start_key  (gclt_pkg::key_t'(s_tdata)),
        .out_free   (out_free),
        .idle       (idle),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register: load a new result, drop a taken one
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = gclt_pkg::M_TDATA_W'(res);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result is only produced when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_tvalid_reg || m_tready))
        else $error("result produced while output register is blocked");

    // One request at a time: no beat is taken right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input taken while a request is in flight");

    // A produced result shows up on the master side next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_tvalid)
        else $error("result lost before the output register");

    // Hit and eviction never come together
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.hit && res.evicted))
        else $error("hit reported together with eviction");

endmodule

// ----- rtl/core/gclt_ram.sv -----
// ----------------------------------------------------------------------------
// gclt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gclt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/gclt_ctrl.sv -----
// ----------------------------------------------------------------------------
// gclt_ctrl: scan and update sequencer of the glyph cache tag store
// Walks the filled slots of the entry RAM one per cycle, looks for a key
// match while tracking the oldest stamp, then writes back the chosen slot.
// ----------------------------------------------------------------------------
module gclt_ctrl #(
    parameter int CACHE_ENTRIES = gclt_pkg::ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              start_kind,
    input  gclt_pkg::key_t    start_key,
    input  logic              out_free,
    output logic              idle,
    output logic              res_valid,
    output gclt_pkg::result_t res
);

    localparam int IDX_W   = $clog2(CACHE_ENTRIES);
    localparam int CNT_W   = $clog2(CACHE_ENTRIES + 1);
    localparam int ENTRY_W = $bits(gclt_pkg::entry_t);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]                     state_reg, state_next;
    gclt_pkg::key_t                 key_reg, key_next;
    logic [CNT_W-1:0]               fill_reg, fill_next;
    logic [gclt_pkg::STAMP_W-1:0]   ctr_reg, ctr_next;
    logic [CNT_W-1:0]               ptr_reg, ptr_next;
    logic                           pend_reg, pend_next;
    logic [IDX_W-1:0]               cmp_idx_reg, cmp_idx_next;
    logic                           hit_reg, hit_next;
    logic [IDX_W-1:0]               hit_idx_reg, hit_idx_next;
    logic [gclt_pkg::STAMP_W-1:0]   min_stamp_reg, min_stamp_next;
    logic [IDX_W-1:0]               min_idx_reg, min_idx_next;

    logic [ENTRY_W-1:0]             rd_data;
    gclt_pkg::entry_t               rd_entry;
    gclt_pkg::entry_t               wr_entry;
    logic                           match;
    logic                           last;
    logic                           issue;
    logic                           do_write;
    logic [CNT_W-1:0]               cmp_cnt;
    logic [gclt_pkg::STAMP_W-1:0]   stamp_new;
    logic [IDX_W-1:0]               victim;
    logic                           evict;
    logic [IDX_W+gclt_pkg::SLOT_W-1:0] slot_ext;

    // Compare the slot read last cycle against the held key
    assign rd_entry  = gclt_pkg::entry_t'(rd_data);
    assign match     = pend_reg && (rd_entry.key == key_reg);
    assign cmp_cnt   = CNT_W'(cmp_idx_reg);
    assign last      = pend_reg && (CNT_W'(cmp_cnt + CNT_W'(1)) == fill_reg);
    assign issue     = (state_reg == ST_SCAN) && !match && (ptr_reg != fill_reg);
    assign stamp_new = ctr_reg + gclt_pkg::STAMP_W'(1);

    // Pick the slot to write: hit slot, first empty slot, or oldest slot
    always_comb begin
        if (hit_reg) begin
            victim = hit_idx_reg;
            evict  = 1'b0;
        end else if (fill_reg != FULL_CNT) begin
            victim = fill_reg[IDX_W-1:0];
            evict  = 1'b0;
        end else begin
            victim = min_idx_reg;
            evict  = 1'b1;
        end
    end

    assign do_write       = (state_reg == ST_WRITE) && out_free;
    assign wr_entry.key   = key_reg;
    assign wr_entry.stamp = stamp_new;

    // Result beat; a flush reports zeros
    assign slot_ext  = (IDX_W + gclt_pkg::SLOT_W)'(victim);
    assign res_valid = ((state_reg == ST_WRITE) || (state_reg == ST_FLUSH)) && out_free;
    assign res.hit     = (state_reg == ST_WRITE) && hit_reg;
    assign res.evicted = (state_reg == ST_WRITE) && evict;
    assign res.slot    = (state_reg == ST_WRITE) ? slot_ext[gclt_pkg::SLOT_W-1:0]
                                                 : '0;
    assign idle = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        ctr_next       = ctr_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        min_stamp_next = min_stamp_reg;
        min_idx_next   = min_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    key_next = start_key;
                    ptr_next = '0;
                    hit_next = 1'b0;
                    if (start_kind == gclt_pkg::KIND_FLUSH) begin
                        fill_next  = '0;
                        ctr_next   = '0;
                        state_next = ST_FLUSH;
                    end else if (fill_reg == '0) begin
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    state_next   = ST_WRITE;
                end else if (pend_reg) begin
                    // Track the oldest stamp, lowest index on a tie
                    if ((cmp_idx_reg == '0) || (rd_entry.stamp < min_stamp_reg)) begin
                        min_stamp_next = rd_entry.stamp;
                        min_idx_next   = cmp_idx_reg;
                    end
                    if (last) begin
                        state_next = ST_WRITE;
                    end
                end
                // Advance the read pointer
                if (issue) begin
                    pend_next    = 1'b1;
                    cmp_idx_next = ptr_reg[IDX_W-1:0];
                    ptr_next     = ptr_reg + CNT_W'(1);
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    ctr_next = stamp_new;
                    if (!hit_reg && (fill_reg != FULL_CNT)) begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            ctr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ctr_reg   <= ctr_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        ptr_reg       <= ptr_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        min_stamp_reg <= min_stamp_next;
        min_idx_reg   <= min_idx_next;
    end

    // Entry store: key and stamp per slot
    gclt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (do_write),
        .wr_addr (victim),
        .wr_data (wr_entry),
        .rd_en   (issue),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

endmodule
